### rtl/rgb2hsl_pkg.sv
// ----------------------------------------------------------------------------
// rgb2hsl_pkg
// Widths, constants and stage payload types shared by the RGB to HSL pipeline.
// ----------------------------------------------------------------------------
package rgb2hsl_pkg;

   // channel and intermediate widths
   localparam int CH_W     = 8;
   localparam int SUM_W    = CH_W + 1;
   localparam int HNUM_W   = 12;              // signed hue numerator before wrap
   localparam int SIXD_W   = 11;              // 6*d, up to 1530
   localparam int QSTEPS   = CH_W;            // quotient bits, one per divider step
   localparam int HDIV_W   = SIXD_W + CH_W;   // 255*num, below 2^19
   localparam int HDSH_W   = SIXD_W + QSTEPS - 1;
   localparam int SDIV_W   = 2 * CH_W;        // 255*d
   localparam int SDSH_W   = CH_W + QSTEPS - 1;

   // saturation denominator switch point and mirror
   localparam logic [SUM_W-1:0] SUM_HALF = 9'd255;
   localparam logic [SUM_W-1:0] SUM_FULL = 9'd510;

   // after max/min classification
   typedef struct packed {
      logic [CH_W-1:0]   light;
      logic [CH_W-1:0]   delta;
      logic [CH_W-1:0]   den;
      logic [HNUM_W-1:0] hue_num;   // two's complement, wrapped in the next stage
   } class_type;

   // divider pipeline payload, hue and saturation side by side
   typedef struct packed {
      logic [HDIV_W-1:0] hue_rem;
      logic [HDSH_W-1:0] hue_dsh;
      logic [CH_W-1:0]   hue_q;
      logic [SDIV_W-1:0] sat_rem;
      logic [SDSH_W-1:0] sat_dsh;
      logic [CH_W-1:0]   sat_q;
      logic [CH_W-1:0]   light;
   } div_type;

endpackage

### rtl/rgb_to_hsl_converter.sv
// Pipeline: a request passes the classify and scale registers and then eight one-bit
// divider step registers; the last step register drives the response.
// Throughput: one pixel per cycle while rsp_ready is high; the eight-step
// hue/saturation divider pipeline sets the depth. Each stage holds its request
// while stalled. Reset: synchronous, clears all stage valid bits; no other state.
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// Pipelined 8-bit RGB to HSL conversion with valid/ready on both sides.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [rgb2hsl_pkg::CH_W-1:0]  req_red,
   input  logic [rgb2hsl_pkg::CH_W-1:0]  req_green,
   input  logic [rgb2hsl_pkg::CH_W-1:0]  req_blue,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [rgb2hsl_pkg::CH_W-1:0]  rsp_hue,
   output logic [rgb2hsl_pkg::CH_W-1:0]  rsp_saturation,
   output logic [rgb2hsl_pkg::CH_W-1:0]  rsp_lightness
);
   import rgb2hsl_pkg::*;

   class_type cls_data;
   logic      cls_valid;
   logic      cls_ready;
   div_type   stage_data  [0:QSTEPS];
   logic      stage_valid [0:QSTEPS];
   logic      stage_ready [0:QSTEPS];

   // max/min and numerators
   rgb2hsl_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_red    (req_red),
      .in_green  (req_green),
      .in_blue   (req_blue),
      .out_valid (cls_valid),
      .out_ready (cls_ready),
      .out_data  (cls_data)
   );

   // wrap and scale by 255
   rgb2hsl_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cls_valid),
      .in_ready  (cls_ready),
      .in_data   (cls_data),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_data  (stage_data[0])
   );

   // one quotient bit per stage, msb first
   for (genvar i = 0; i < QSTEPS; i++) begin : g_div
      rgb2hsl_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   // last divider stage is the output register
   assign stage_ready[QSTEPS] = rsp_ready;
   assign rsp_valid           = stage_valid[QSTEPS];
   assign rsp_hue             = stage_data[QSTEPS].hue_q;
   assign rsp_saturation      = stage_data[QSTEPS].sat_q;
   assign rsp_lightness       = stage_data[QSTEPS].light;

   // a taken output always frees room at the input
   assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("pipeline blocked input while output was taken");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled result keeps its value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable({rsp_hue, rsp_saturation, rsp_lightness})))
      else $error("stalled result lost or changed");

endmodule

### rtl/rgb2hsl_classify.sv
// ----------------------------------------------------------------------------
// rgb2hsl_classify
// First stage: max/min search, lightness, saturation denominator and the
// signed hue numerator for the dominant channel.
// ----------------------------------------------------------------------------
module rgb2hsl_classify (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [rgb2hsl_pkg::CH_W-1:0]  in_red,
   input  logic [rgb2hsl_pkg::CH_W-1:0]  in_green,
   input  logic [rgb2hsl_pkg::CH_W-1:0]  in_blue,
   output logic                          out_valid,
   input  logic                          out_ready,
   output rgb2hsl_pkg::class_type        out_data
);
   import rgb2hsl_pkg::*;

   logic              valid_ff;
   class_type         data_ff;
   class_type         data_in;
   logic [CH_W-1:0]   mx;
   logic [CH_W-1:0]   mn;
   logic [CH_W-1:0]   delta;
   logic [SUM_W-1:0]  sum;
   logic [SUM_W-1:0]  mirror;
   logic [CH_W-1:0]   diff_a;
   logic [CH_W-1:0]   diff_b;
   logic [HNUM_W-1:0] base;

   // smallest channel
   always_comb begin
      mn = in_red;
      if (in_green < mn) mn = in_green;
      if (in_blue < mn) mn = in_blue;
   end

   assign mx = (in_red >= in_green && in_red >= in_blue) ? in_red :
               (in_green >= in_blue) ? in_green : in_blue;
   assign delta = mx - mn;

   // dominant channel picks the sector base and the difference, red wins ties
   always_comb begin
      priority if (in_red >= in_green && in_red >= in_blue) begin
         base   = '0;
         diff_a = in_green;
         diff_b = in_blue;
      end else if (in_green >= in_blue) begin
         base   = {3'b000, delta, 1'b0};
         diff_a = in_blue;
         diff_b = in_red;
      end else begin
         base   = {2'b00, delta, 2'b00};
         diff_a = in_red;
         diff_b = in_green;
      end
   end

   assign sum    = {1'b0, mx} + {1'b0, mn};
   assign mirror = SUM_FULL - sum;

   always_comb begin
      data_in.light   = sum[SUM_W-1:1];
      data_in.delta   = delta;
      data_in.den     = (sum < SUM_HALF) ? sum[CH_W-1:0] : mirror[CH_W-1:0];
      data_in.hue_num = base + {{(HNUM_W-CH_W){1'b0}}, diff_a}
                             - {{(HNUM_W-CH_W){1'b0}}, diff_b};
   end

   // stage register
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/rgb2hsl_scale.sv
// ----------------------------------------------------------------------------
// rgb2hsl_scale
// Second stage: wraps the hue numerator, scales both numerators by 255 and
// lines up both divisors for the first quotient bit.
// ----------------------------------------------------------------------------
module rgb2hsl_scale (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  rgb2hsl_pkg::class_type  in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rgb2hsl_pkg::div_type    out_data
);
   import rgb2hsl_pkg::*;

   logic              valid_ff;
   div_type           data_ff;
   div_type           data_in;
   logic [SIXD_W-1:0] six_d;
   logic [HNUM_W-1:0] num_wrap;
   logic [SIXD_W-1:0] num;
   logic              grey;

   assign six_d = {1'b0, in_data.delta, 2'b00} + {2'b00, in_data.delta, 1'b0};
   assign grey  = (in_data.delta == '0);

   // negative hue gains one turn
   assign num_wrap = in_data.hue_num[HNUM_W-1] ?
                     in_data.hue_num + {1'b0, six_d} : in_data.hue_num;
   assign num      = num_wrap[SIXD_W-1:0];

   // x*255 as (x<<8)-x; grey pixels get a nonzero divisor so the quotient is 0
   always_comb begin
      data_in.hue_rem = {num, 8'h00} - {8'h00, num};
      data_in.hue_dsh = grey ? '1 : {six_d, {(QSTEPS-1){1'b0}}};
      data_in.hue_q   = '0;
      data_in.sat_rem = {in_data.delta, 8'h00} - {8'h00, in_data.delta};
      data_in.sat_dsh = grey ? '1 : {in_data.den, {(QSTEPS-1){1'b0}}};
      data_in.sat_q   = '0;
      data_in.light   = in_data.light;
   end

   // stage register
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### rtl/rgb2hsl_div_step.sv
// ----------------------------------------------------------------------------
// rgb2hsl_div_step
// One restoring division step for hue and saturation: produces one quotient
// bit of each and halves the aligned divisors for the next step.
// ----------------------------------------------------------------------------
module rgb2hsl_div_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  rgb2hsl_pkg::div_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output rgb2hsl_pkg::div_type  out_data
);
   import rgb2hsl_pkg::*;

   logic    valid_ff;
   div_type data_ff;
   div_type data_in;
   logic    hue_fit;
   logic    sat_fit;

   assign hue_fit = (in_data.hue_rem >= {1'b0, in_data.hue_dsh});
   assign sat_fit = (in_data.sat_rem >= {1'b0, in_data.sat_dsh});

   // subtract when the shifted divisor fits, shift the bit into the quotient
   always_comb begin
      data_in.hue_rem = hue_fit ? in_data.hue_rem - {1'b0, in_data.hue_dsh}
                                : in_data.hue_rem;
      data_in.hue_dsh = in_data.hue_dsh >> 1;
      data_in.hue_q   = {in_data.hue_q[CH_W-2:0], hue_fit};
      data_in.sat_rem = sat_fit ? in_data.sat_rem - {1'b0, in_data.sat_dsh}
                                : in_data.sat_rem;
      data_in.sat_dsh = in_data.sat_dsh >> 1;
      data_in.sat_q   = {in_data.sat_q[CH_W-2:0], sat_fit};
      data_in.light   = in_data.light;
   end

   // stage register
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // remainder stays below the divisor of the step just taken
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.hue_rem < {data_ff.hue_dsh, 1'b1}))
      else $error("hue remainder not below divisor");

   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.sat_rem < {data_ff.sat_dsh, 1'b1}))
      else $error("saturation remainder not below divisor");

   // a stalled stage keeps its request
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |=> (valid_ff && $stable(data_ff)))
      else $error("stalled divider stage lost or changed its request");

endmodule
